// ----- hdl/tpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tpp_pkg;

  localparam int PWR_W   = 16;
  localparam int CNT_W   = 16;
  localparam int TICK_W  = 19;
  localparam int OVS_W   = 16;
  localparam int PHASE_W = 3;

  // Restoring divider: one quotient bit per step over a 16-bit magnitude.
  localparam int DIV_STEPS = PWR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // APB register map, one 32-bit word per register.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ACCEL_END   = 3'd0,
    REG_DECEL_START = 3'd1,
    REG_TARGET      = 3'd2,
    REG_OVERSHOOT   = 3'd3,
    REG_MAX_POWER   = 3'd4,
    REG_FLOOR_POWER = 3'd5,
    REG_REV_POWER   = 3'd6
  } reg_idx_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_ACCEL   = 3'd0,
    PH_CRUISE  = 3'd1,
    PH_DECEL   = 3'd2,
    PH_HOLD    = 3'd3,
    PH_REVERSE = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [TICK_W-1:0]       accel_end;
    logic [TICK_W-1:0]       decel_start;
    logic [TICK_W-1:0]       target;
    logic [OVS_W-1:0]        overshoot;
    logic signed [PWR_W-1:0] max_power;
    logic signed [PWR_W-1:0] floor_power;
    logic signed [PWR_W-1:0] reverse_power;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
  } stat_t;

endpackage
`default_nettype wire

// ----- hdl/tpp_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpp_regs
  import tpp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_end     <= TICK_W'(205);
      cfg_q.decel_start   <= TICK_W'(3479);
      cfg_q.target        <= '0;
      cfg_q.overshoot     <= OVS_W'(150);
      cfg_q.max_power     <= PWR_W'(25600);
      cfg_q.floor_power   <= PWR_W'(2048);
      cfg_q.reverse_power <= -PWR_W'(1280);
    end else if (wr_en) begin
      case (idx)
        REG_ACCEL_END:   cfg_q.accel_end     <= pwdata[TICK_W-1:0];
        REG_DECEL_START: cfg_q.decel_start   <= pwdata[TICK_W-1:0];
        REG_TARGET:      cfg_q.target        <= pwdata[TICK_W-1:0];
        REG_OVERSHOOT:   cfg_q.overshoot     <= pwdata[OVS_W-1:0];
        REG_MAX_POWER:   cfg_q.max_power     <= pwdata[PWR_W-1:0];
        REG_FLOOR_POWER: cfg_q.floor_power   <= pwdata[PWR_W-1:0];
        REG_REV_POWER:   cfg_q.reverse_power <= pwdata[PWR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACCEL_END:   prdata = APB_DATA_W'(cfg_q.accel_end);
      REG_DECEL_START: prdata = APB_DATA_W'(cfg_q.decel_start);
      REG_TARGET:      prdata = APB_DATA_W'(cfg_q.target);
      REG_OVERSHOOT:   prdata = APB_DATA_W'(cfg_q.overshoot);
      REG_MAX_POWER:   prdata = APB_DATA_W'(cfg_q.max_power);
      REG_FLOOR_POWER: prdata = APB_DATA_W'(cfg_q.floor_power);
      REG_REV_POWER:   prdata = APB_DATA_W'(cfg_q.reverse_power);
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/tpp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpp_ctrl
  import tpp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e                 state_q, state_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   last_step;

  assign last_step   = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP:  state_d = stat_i.needs_div ? ST_DIV : ST_FINISH;
      ST_DIV:    if (last_step) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cnt_d       = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = '0;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
      end
      ST_FINISH: begin
        // The result register is loaded only once the previous result is gone.
        cmd_o.finish = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
    out_valid_d = cmd_o.finish | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tpp_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpp_dp
  import tpp_pkg::*;
#(
  parameter int POS_WIDTH = 20
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cmd_t                        cmd_i,
  output stat_t                            stat_o,
  input  wire cfg_t                        cfg_i,
  input  wire logic signed [POS_WIDTH-1:0] position_i,
  output logic signed [PWR_W-1:0]          drive_power_o,
  output logic        [PHASE_W-1:0]        phase_o,
  output logic        [CNT_W-1:0]          decel_steps_o
);

  // Compare width covers the position and target plus overshoot with room for
  // the distance between them as a positive number.
  localparam int CMP_W = ((POS_WIDTH > TICK_W + 2) ? POS_WIDTH : TICK_W + 2) + 2;
  localparam int DIV_W = CMP_W - 1;

  logic signed [POS_WIDTH-1:0] pos_q;
  phase_e                      phase_q, phase_d, out_phase_q;
  logic                        neg_q;
  logic [DIV_W-1:0]            div_q, rem_q;
  logic [PWR_W-1:0]            quo_q;
  logic signed [PWR_W-1:0]     power_q;
  logic [CNT_W-1:0]            cnt_q;

  logic signed [CMP_W-1:0]     pos_s, aend_s, dstart_s, tgt_s, stop_s;
  logic signed [CMP_W-1:0]     distance;
  logic signed [PWR_W-1:0]     goal;
  logic signed [PWR_W:0]       diff;
  logic [PWR_W:0]              diff_mag;
  logic [DIV_W:0]              trial;
  logic [DIV_W:0]              trial_sub;
  logic signed [PWR_W:0]       quo_s;
  logic signed [PWR_W:0]       approach;

  assign pos_s    = CMP_W'(pos_q);
  assign aend_s   = signed'(CMP_W'(cfg_i.accel_end));
  assign dstart_s = signed'(CMP_W'(cfg_i.decel_start));
  assign tgt_s    = signed'(CMP_W'(cfg_i.target));
  assign stop_s   = signed'(CMP_W'(cfg_i.target) + CMP_W'(cfg_i.overshoot));

  always_comb begin
    if (pos_s < aend_s) begin
      phase_d = PH_ACCEL;
    end else if (pos_s < dstart_s) begin
      phase_d = PH_CRUISE;
    end else if (pos_s < tgt_s) begin
      phase_d = PH_DECEL;
    end else if (pos_s >= stop_s) begin
      phase_d = PH_REVERSE;
    end else begin
      phase_d = PH_HOLD;
    end
  end

  assign stat_o.needs_div = (phase_d == PH_ACCEL) || (phase_d == PH_DECEL);

  assign distance = (phase_d == PH_ACCEL) ? (aend_s - pos_s) : (stop_s - pos_s);
  assign goal     = (phase_d == PH_ACCEL) ? cfg_i.max_power : cfg_i.floor_power;
  assign diff     = (PWR_W + 1)'(goal) - (PWR_W + 1)'(power_q);
  assign diff_mag = diff[PWR_W] ? unsigned'(-diff) : unsigned'(diff);

  // One restoring step: shift the next dividend bit into the remainder.
  assign trial     = {rem_q, quo_q[PWR_W-1]};
  assign trial_sub = trial - {1'b0, div_q};

  assign quo_s    = neg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
  assign approach = (PWR_W + 1)'(power_q) + quo_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pos_q <= position_i;
    end
    if (cmd_i.setup) begin
      phase_q <= phase_d;
      neg_q   <= diff[PWR_W];
      div_q   <= distance[DIV_W-1:0];
      rem_q   <= '0;
      quo_q   <= diff_mag[PWR_W-1:0];
    end else if (cmd_i.step) begin
      if (!trial_sub[DIV_W]) begin
        rem_q <= trial_sub[DIV_W-1:0];
        quo_q <= {quo_q[PWR_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DIV_W-1:0];
        quo_q <= {quo_q[PWR_W-2:0], 1'b0};
      end
    end
  end

  // Power and the decel count double as the result register; they change only
  // when a result is loaded for output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q     <= '0;
      cnt_q       <= '0;
      out_phase_q <= PH_ACCEL;
    end else if (cmd_i.finish) begin
      out_phase_q <= phase_q;
      case (phase_q)
        PH_ACCEL:   power_q <= approach[PWR_W-1:0];
        PH_CRUISE:  power_q <= cfg_i.max_power;
        PH_DECEL: begin
          power_q <= approach[PWR_W-1:0];
          if (cnt_q != CNT_MAX) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        PH_REVERSE: power_q <= cfg_i.reverse_power;
        default:    ;
      endcase
    end
  end

  assign drive_power_o = power_q;
  assign phase_o       = out_phase_q;
  assign decel_steps_o = cnt_q;

endmodule
`default_nettype wire

// ----- hdl/trapezoidal_power_profile.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Accel and decel samples pass through a 16-step restoring divider; cruise, hold
// and reverse samples skip it and go straight from setup to finish.
// A new sample is taken only once the current one has reached the result register.
// A waiting result does not block the next input transfer.
// Reset is asynchronous and active low: power, decel count, control state and config
// registers return to their documented defaults; datapath work registers are not reset.
module trapezoidal_power_profile
  import tpp_pkg::*;
#(
  parameter int POS_WIDTH = 20
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [APB_ADDR_W-1:0]       paddr,
  input  wire logic [APB_DATA_W-1:0]       pwdata,
  output logic      [APB_DATA_W-1:0]       prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [POS_WIDTH-1:0] position_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [PWR_W-1:0]          drive_power_o,
  output logic        [PHASE_W-1:0]        phase_o,
  output logic        [CNT_W-1:0]          decel_steps_o
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  tpp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tpp_dp #(
    .POS_WIDTH (POS_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_i         (cfg),
    .position_i    (position_i),
    .drive_power_o (drive_power_o),
    .phase_o       (phase_o),
    .decel_steps_o (decel_steps_o)
  );

endmodule
`default_nettype wire

// ----- hdl/tpp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpp_sva
  import tpp_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic signed [PWR_W-1:0] drive_power_o,
  input wire logic [PHASE_W-1:0]      phase_o,
  input wire logic [CNT_W-1:0]        decel_steps_o
);

  // A pending result stays offered until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transfer");

  // A pending result keeps its payload until its transfer.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(drive_power_o) && $stable(phase_o) && $stable(decel_steps_o))
    else $error("result payload changed before transfer");

  // The decel count saturates and never goes back down.
  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decel_steps_o >= $past(decel_steps_o))
    else $error("decel count decreased");

  // In the cycle after an input transfer, the input is not ready.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken back to back");

  // A result never shows in the cycle right after its input transfer.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind trapezoidal_power_profile tpp_sva u_tpp_sva (.*);
`default_nettype wire
